// File: src/ip_port_blocklist_filter_assert.svh
// Assertion macros for the blocklist filter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef IP_PORT_BLOCKLIST_FILTER_ASSERT_SVH
`define IP_PORT_BLOCKLIST_FILTER_ASSERT_SVH

// same-cycle implication
`define IPBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ipbf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the blocklist filter.
// No dependencies.
package ipbf_pkg;

    localparam int OPCODE_W = 3;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int PROTO_W  = 8;
    localparam int REASON_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CHECK        = 3'd0,
        OP_ADD_SRC_ADDR = 3'd1,
        OP_ADD_DST_ADDR = 3'd2,
        OP_ADD_SRC_PORT = 3'd3,
        OP_ADD_DST_PORT = 3'd4
    } opcode_t;

    localparam logic [REASON_W-1:0] REASON_NONE = 2'd0;
    localparam logic [REASON_W-1:0] REASON_SRC  = 2'd1;
    localparam logic [REASON_W-1:0] REASON_DST  = 2'd2;
    localparam logic [REASON_W-1:0] REASON_PORT = 2'd3;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    typedef enum logic [1:0] {
        LIST_SRC_ADDR,
        LIST_DST_ADDR,
        LIST_SRC_PORT,
        LIST_DST_PORT
    } list_sel_t;

    typedef struct packed {
        logic      en;
        list_sel_t sel;
    } lists_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// File: src/ipbf_lists.sv
`timescale 1ns / 1ps
// The four block list memories: one write port, one shared read address.
// Depends on ipbf_pkg.
module ipbf_lists #(
    parameter int  LIST_DEPTH = 128,
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  logic                       clk,
    input  ipbf_pkg::lists_wr_t        wr,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [ipbf_pkg::ADDR_W-1:0] wr_data,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [ipbf_pkg::ADDR_W-1:0] src_addr_q,
    output logic [ipbf_pkg::ADDR_W-1:0] dst_addr_q,
    output logic [ipbf_pkg::PORT_W-1:0] source_port_q,
    output logic [ipbf_pkg::PORT_W-1:0] dst_port_q
);
    import ipbf_pkg::*;

    logic [ADDR_W-1:0] src_addr_mem [LIST_DEPTH];
    logic [ADDR_W-1:0] dst_addr_mem [LIST_DEPTH];
    logic [PORT_W-1:0] source_port_mem [LIST_DEPTH];
    logic [PORT_W-1:0] dst_port_mem [LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            case (wr.sel)
                LIST_SRC_ADDR: src_addr_mem[wr_addr] <= wr_data;
                LIST_DST_ADDR: dst_addr_mem[wr_addr] <= wr_data;
                LIST_SRC_PORT: source_port_mem[wr_addr] <= wr_data[PORT_W-1:0];
                LIST_DST_PORT: dst_port_mem[wr_addr] <= wr_data[PORT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        src_addr_q    <= src_addr_mem[rd_addr];
        dst_addr_q    <= dst_addr_mem[rd_addr];
        source_port_q <= source_port_mem[rd_addr];
        dst_port_q    <= dst_port_mem[rd_addr];
    end

endmodule

// File: src/ip_port_blocklist_filter.sv
`timescale 1ns / 1ps
// IPv4 address and port blocklist filter: top level, sequencer and fill counts.
// Depends on ipbf_pkg, ipbf_lists and ip_port_blocklist_filter_assert.svh.
//
// Input channel (in_valid/in_ready) carries one item: a packet check or an
// insert into one of four lists. Output channel (out_valid/out_ready) returns
// exactly one result item per input item, in order.
// The block takes one item at a time; in_ready is high only while idle.
// Inserts: the list is written in ST_INSERT and the result is passed on in ST_DONE.
// Checks: all four lists are read in parallel, one entry per cycle, for as
// many entries as the fullest list holds; the walk ends once the last entry
// read has been compared, and the result then goes out through ST_DONE. The
// next item is accepted once the sequencer is back in idle; this list walk sets the rate.
// The result sits in an output register; the next item is accepted while it
// waits. A stalled receiver holds the result, and a following item's result
// waits in the sequencer until the register frees.
// Reset empties all four lists (fill counts to zero); list contents are not
// cleared and entries at or above a fill count can never match.
module ip_port_blocklist_filter #(
    parameter int LIST_DEPTH = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ipbf_pkg::OPCODE_W-1:0]  opcode,
    input  logic [ipbf_pkg::ADDR_W-1:0]    src_addr,
    input  logic [ipbf_pkg::ADDR_W-1:0]    dst_addr,
    input  logic [ipbf_pkg::PROTO_W-1:0]   protocol,
    input  logic [ipbf_pkg::PORT_W-1:0]    source_port,
    input  logic [ipbf_pkg::PORT_W-1:0]    dst_port,
    input  logic [ipbf_pkg::ADDR_W-1:0]    rule_addr,
    input  logic [ipbf_pkg::PORT_W-1:0]    rule_port,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           drop,
    output logic [ipbf_pkg::REASON_W-1:0]  match_reason,
    output logic                           rule_stored
);
    import ipbf_pkg::*;

    `include "ip_port_blocklist_filter_assert.svh"

    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FILL_W = $clog2(LIST_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(LIST_DEPTH);

    state_t state_reg, state_next;

    logic [FILL_W-1:0] sa_fill_reg, sa_fill_next;
    logic [FILL_W-1:0] da_fill_reg, da_fill_next;
    logic [FILL_W-1:0] sp_fill_reg, sp_fill_next;
    logic [FILL_W-1:0] dp_fill_reg, dp_fill_next;

    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] scan_end_reg, scan_end_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic              rd_en;

    logic [OPCODE_W-1:0] op_reg;
    logic [ADDR_W-1:0]   src_addr_reg, dst_addr_reg, rule_addr_reg;
    logic [PROTO_W-1:0]  proto_reg;
    logic [PORT_W-1:0]   source_port_reg, dst_port_reg, rule_port_reg;

    logic sa_hit_reg, sa_hit_next;
    logic da_hit_reg, da_hit_next;
    logic sp_hit_reg, sp_hit_next;
    logic dp_hit_reg, dp_hit_next;

    logic                res_drop_reg, res_drop_next;
    logic [REASON_W-1:0] res_reason_reg, res_reason_next;
    logic                res_stored_reg, res_stored_next;

    logic                out_valid_reg, out_valid_next;
    logic                drop_reg, drop_next;
    logic [REASON_W-1:0] reason_reg, reason_next;
    logic                stored_reg, stored_next;

    logic [FILL_W-1:0] max_a, max_p, max_all;
    logic              accept;
    logic              ports_used;

    lists_wr_t         wr_ctrl;
    logic [IDX_W-1:0]  wr_addr;
    logic [ADDR_W-1:0] wr_data;
    logic [ADDR_W-1:0] sa_q, da_q;
    logic [PORT_W-1:0] sp_q, dp_q;

    ipbf_lists #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_lists (
        .clk           (clk),
        .wr            (wr_ctrl),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (idx_reg[IDX_W-1:0]),
        .src_addr_q    (sa_q),
        .dst_addr_q    (da_q),
        .source_port_q (sp_q),
        .dst_port_q    (dp_q)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign drop         = drop_reg;
    assign match_reason = reason_reg;
    assign rule_stored  = stored_reg;

    assign max_a      = (sa_fill_reg > da_fill_reg) ? sa_fill_reg : da_fill_reg;
    assign max_p      = (sp_fill_reg > dp_fill_reg) ? sp_fill_reg : dp_fill_reg;
    assign max_all    = (max_a > max_p) ? max_a : max_p;
    assign ports_used = (proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP);

    always_comb
    begin
        state_next      = state_reg;
        sa_fill_next    = sa_fill_reg;
        da_fill_next    = da_fill_reg;
        sp_fill_next    = sp_fill_reg;
        dp_fill_next    = dp_fill_reg;
        idx_next        = idx_reg;
        scan_end_next   = scan_end_reg;
        sa_hit_next     = sa_hit_reg;
        da_hit_next     = da_hit_reg;
        sp_hit_next     = sp_hit_reg;
        dp_hit_next     = dp_hit_reg;
        res_drop_next   = res_drop_reg;
        res_reason_next = res_reason_reg;
        res_stored_next = res_stored_reg;
        drop_next       = drop_reg;
        reason_next     = reason_reg;
        stored_next     = stored_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        wr_ctrl.en      = 1'b0;
        wr_ctrl.sel     = LIST_SRC_ADDR;
        wr_addr         = '0;
        wr_data         = rule_addr_reg;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = (opcode == OP_CHECK) ? ST_SCAN : ST_INSERT;
                    idx_next      = '0;
                    scan_end_next = max_all;
                    sa_hit_next   = 1'b0;
                    da_hit_next   = 1'b0;
                    sp_hit_next   = 1'b0;
                    dp_hit_next   = 1'b0;
                end
            end
            ST_INSERT:
            begin
                res_drop_next   = 1'b0;
                res_reason_next = REASON_NONE;
                res_stored_next = 1'b0;
                case (op_reg)
                    OP_ADD_SRC_ADDR:
                    begin
                        if (sa_fill_reg < DEPTH_F)
                        begin
                            wr_ctrl.en      = 1'b1;
                            wr_ctrl.sel     = LIST_SRC_ADDR;
                            wr_addr         = sa_fill_reg[IDX_W-1:0];
                            sa_fill_next    = sa_fill_reg + 1'b1;
                            res_stored_next = 1'b1;
                        end
                    end
                    OP_ADD_DST_ADDR:
                    begin
                        if (da_fill_reg < DEPTH_F)
                        begin
                            wr_ctrl.en      = 1'b1;
                            wr_ctrl.sel     = LIST_DST_ADDR;
                            wr_addr         = da_fill_reg[IDX_W-1:0];
                            da_fill_next    = da_fill_reg + 1'b1;
                            res_stored_next = 1'b1;
                        end
                    end
                    OP_ADD_SRC_PORT:
                    begin
                        if (sp_fill_reg < DEPTH_F)
                        begin
                            wr_ctrl.en      = 1'b1;
                            wr_ctrl.sel     = LIST_SRC_PORT;
                            wr_addr         = sp_fill_reg[IDX_W-1:0];
                            wr_data         = {{(ADDR_W-PORT_W){1'b0}}, rule_port_reg};
                            sp_fill_next    = sp_fill_reg + 1'b1;
                            res_stored_next = 1'b1;
                        end
                    end
                    OP_ADD_DST_PORT:
                    begin
                        if (dp_fill_reg < DEPTH_F)
                        begin
                            wr_ctrl.en      = 1'b1;
                            wr_ctrl.sel     = LIST_DST_PORT;
                            wr_addr         = dp_fill_reg[IDX_W-1:0];
                            wr_data         = {{(ADDR_W-PORT_W){1'b0}}, rule_port_reg};
                            dp_fill_next    = dp_fill_reg + 1'b1;
                            res_stored_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                rd_en = (idx_reg < scan_end_reg);
                if (rd_en)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                // compare the entry read last cycle against the item's fields, within each list's fill
                if (rd_vld_reg)
                begin
                    sa_hit_next = sa_hit_reg ||
                                  ((rd_idx_reg < sa_fill_reg) && (sa_q == src_addr_reg));
                    da_hit_next = da_hit_reg ||
                                  ((rd_idx_reg < da_fill_reg) && (da_q == dst_addr_reg));
                    sp_hit_next = sp_hit_reg ||
                                  ((rd_idx_reg < sp_fill_reg) && (sp_q == source_port_reg));
                    dp_hit_next = dp_hit_reg ||
                                  ((rd_idx_reg < dp_fill_reg) && (dp_q == dst_port_reg));
                end
                if (!rd_en && !rd_vld_reg)
                begin
                    res_stored_next = 1'b0;
                    if (sa_hit_reg)
                    begin
                        res_reason_next = REASON_SRC;
                    end
                    else if (da_hit_reg)
                    begin
                        res_reason_next = REASON_DST;
                    end
                    else if (ports_used && (sp_hit_reg || dp_hit_reg))
                    begin
                        res_reason_next = REASON_PORT;
                    end
                    else
                    begin
                        res_reason_next = REASON_NONE;
                    end
                    res_drop_next = sa_hit_reg || da_hit_reg ||
                                    (ports_used && (sp_hit_reg || dp_hit_reg));
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    drop_next      = res_drop_reg;
                    reason_next    = res_reason_reg;
                    stored_next    = res_stored_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_vld_next = rd_en;
        rd_idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sa_fill_reg   <= '0;
            da_fill_reg   <= '0;
            sp_fill_reg   <= '0;
            dp_fill_reg   <= '0;
            idx_reg       <= '0;
            scan_end_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sa_fill_reg   <= sa_fill_next;
            da_fill_reg   <= da_fill_next;
            sp_fill_reg   <= sp_fill_next;
            dp_fill_reg   <= dp_fill_next;
            idx_reg       <= idx_next;
            scan_end_reg  <= scan_end_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= opcode;
            src_addr_reg    <= src_addr;
            dst_addr_reg    <= dst_addr;
            proto_reg       <= protocol;
            source_port_reg <= source_port;
            dst_port_reg    <= dst_port;
            rule_addr_reg   <= rule_addr;
            rule_port_reg   <= rule_port;
        end
        rd_idx_reg     <= rd_idx_next;
        sa_hit_reg     <= sa_hit_next;
        da_hit_reg     <= da_hit_next;
        sp_hit_reg     <= sp_hit_next;
        dp_hit_reg     <= dp_hit_next;
        res_drop_reg   <= res_drop_next;
        res_reason_reg <= res_reason_next;
        res_stored_reg <= res_stored_next;
        drop_reg       <= drop_next;
        reason_reg     <= reason_next;
        stored_reg     <= stored_next;
    end

    `IPBF_ASSERT_NOW(a_fill_bound, 1'b1,
        (sa_fill_reg <= DEPTH_F) && (da_fill_reg <= DEPTH_F) &&
        (sp_fill_reg <= DEPTH_F) && (dp_fill_reg <= DEPTH_F),
        "list fill count beyond depth")
    `IPBF_ASSERT_NOW(a_result_consistent, out_valid_reg,
        (drop_reg == (reason_reg != REASON_NONE)) && !(drop_reg && stored_reg),
        "inconsistent result fields")
    `IPBF_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE,
        "sequencer stayed idle after accepting an item")
    `IPBF_ASSERT_NOW(a_scan_bound, state_reg == ST_SCAN,
        (idx_reg <= scan_end_reg) && (scan_end_reg <= DEPTH_F),
        "list walk ran past its end")
    `IPBF_ASSERT_NOW(a_write_only_insert, wr_ctrl.en, state_reg == ST_INSERT,
        "list written outside an insert")

endmodule
